/* hw/rtl/sfrx_pkg.sv */
// shared types and constants of the servo response frame receiver
// no dependencies
`timescale 1ns / 1ps

package sfrx_pkg;

   localparam int HEADER_SPAN = 7;
   localparam logic [2:0] SPAN_FILL = 3'd7;
   localparam logic [2:0] SPAN_LAST = 3'd6;
   localparam logic [7:0] SPAN_BYTES = 8'd7;
   localparam logic [7:0] SYNC_BYTE = 8'hFF;
   localparam logic [7:0] REPLY_BIT = 8'h40;
   localparam logic [7:0] CHECK_MASK = 8'hFE;

   localparam logic [1:0] ACT_BYTE = 2'd0;
   localparam logic [1:0] ACT_TICK = 2'd1;
   localparam logic [1:0] ACT_START = 2'd2;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;
   localparam logic [1:0] ST_TIMEOUT = 2'd2;

   localparam logic CSR_FRAME_LENGTH = 1'b0;
   localparam logic CSR_TIMEOUT = 1'b1;

   localparam logic [7:0] FRAME_LENGTH_RESET = 8'd13;
   localparam logic [15:0] TIMEOUT_RESET = 16'd80;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [7:0] byte_index;
      logic       last;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  frame_length;
      logic [15:0] timeout_limit_ms;
   } cfg_type;

   // one queued job: a single result, or a burst of the whole header window
   typedef struct packed {
      logic                             burst;
      logic [HEADER_SPAN-1:0][7:0]      bytes;
      logic [7:0]                       index;
      logic                             last;
      logic [1:0]                       status;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

/* hw/rtl/sfrx_front.sv */
// front part: accepts words, tracks hunt and lock state, queues result jobs
// depends on sfrx_pkg
`timescale 1ns / 1ps

module sfrx_front (
   input  logic              clock,
   input  logic              reset,
   input  sfrx_pkg::cfg_type cfg,
   input  logic              req_valid,
   output logic              req_ready,
   input  sfrx_pkg::req_type req_data,
   input  logic              q_full,
   output logic              q_push,
   output sfrx_pkg::job_type q_job
);

   logic [sfrx_pkg::HEADER_SPAN-1:0][7:0] window_ff, window_in;
   logic [2:0]  fill_ff, fill_in;
   logic        locked_ff, locked_in;
   logic [7:0]  taken_ff, taken_in;
   logic [7:0]  xor_ff, xor_in;
   logic [7:0]  chk1_ff, chk1_in;
   logic [7:0]  chk2_ff, chk2_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic        armed_ff, armed_in;

   logic        accept;
   logic [7:0]  eff_len;
   logic [15:0] elapsed_inc;
   logic [7:0]  xor_byte, xor_lock;
   logic [8:0]  taken_inc;
   logic        fin;
   logic [sfrx_pkg::HEADER_SPAN-1:0][7:0] shifted;
   logic        hit;
   logic [7:0]  c1, c2;

   function automatic logic [1:0] check_status(input logic [7:0] x, input logic [7:0] r1,
                                               input logic [7:0] r2);
      logic [7:0] k1, k2;
      k1 = x & sfrx_pkg::CHECK_MASK;
      k2 = ~k1 & sfrx_pkg::CHECK_MASK;
      return (k1 == r1 && k2 == r2) ? sfrx_pkg::ST_OK : sfrx_pkg::ST_CHECK;
   endfunction

   assign req_ready = !q_full;
   assign accept = req_valid && !q_full;

   assign eff_len = (cfg.frame_length < sfrx_pkg::SPAN_BYTES) ? sfrx_pkg::SPAN_BYTES
                                                               : cfg.frame_length;
   assign elapsed_inc = (elapsed_ff == 16'hFFFF) ? elapsed_ff : elapsed_ff + 16'd1;
   assign xor_byte = xor_ff ^ req_data.rx_byte;
   assign taken_inc = {1'b0, taken_ff} + 9'd1;
   assign fin = taken_inc >= {1'b0, eff_len};

   // window shifts in at the top on each byte while hunting; it is only examined once full
   always_comb begin
      for (int i = 0; i < sfrx_pkg::HEADER_SPAN - 1; i++) begin
         shifted[i] = window_ff[i+1];
      end
      shifted[sfrx_pkg::HEADER_SPAN-1] = req_data.rx_byte;
   end

   assign hit = (fill_ff >= sfrx_pkg::SPAN_LAST) &&
                shifted[0] == sfrx_pkg::SYNC_BYTE &&
                shifted[1] == sfrx_pkg::SYNC_BYTE &&
                (shifted[4] & sfrx_pkg::REPLY_BIT) != 8'd0 &&
                shifted[2] == cfg.frame_length;
   assign xor_lock = shifted[2] ^ shifted[3] ^ shifted[4];
   assign c1 = shifted[5];
   assign c2 = shifted[6];

   always_comb begin
      window_in  = window_ff;
      fill_in    = fill_ff;
      locked_in  = locked_ff;
      taken_in   = taken_ff;
      xor_in     = xor_ff;
      chk1_in    = chk1_ff;
      chk2_in    = chk2_ff;
      elapsed_in = elapsed_ff;
      armed_in   = armed_ff;
      q_push     = 1'b0;
      q_job      = '0;
      if (accept) begin
         if (req_data.action == sfrx_pkg::ACT_START) begin
            window_in  = '0;
            fill_in    = '0;
            locked_in  = 1'b0;
            taken_in   = '0;
            xor_in     = '0;
            chk1_in    = '0;
            chk2_in    = '0;
            elapsed_in = '0;
            armed_in   = 1'b1;
         end else if (armed_ff && req_data.action == sfrx_pkg::ACT_TICK) begin
            elapsed_in = elapsed_inc;
            if (elapsed_inc >= cfg.timeout_limit_ms) begin
               q_push       = 1'b1;
               q_job.last   = 1'b1;
               q_job.status = sfrx_pkg::ST_TIMEOUT;
               armed_in     = 1'b0;
            end
         end else if (armed_ff && req_data.action == sfrx_pkg::ACT_BYTE) begin
            if (locked_ff) begin
               xor_in         = xor_byte;
               taken_in       = taken_inc[7:0];
               q_push         = 1'b1;
               q_job.bytes[0] = req_data.rx_byte;
               q_job.index    = taken_ff;
               q_job.last     = fin;
               q_job.status   = fin ? check_status(xor_byte, chk1_ff, chk2_ff)
                                    : sfrx_pkg::ST_OK;
               if (fin) begin
                  armed_in = 1'b0;
               end
            end else begin
               window_in = shifted;
               if (fill_ff != sfrx_pkg::SPAN_FILL) begin
                  fill_in = fill_ff + 3'd1;
               end
               if (hit) begin
                  locked_in   = 1'b1;
                  xor_in      = xor_lock;
                  chk1_in     = c1;
                  chk2_in     = c2;
                  taken_in    = sfrx_pkg::SPAN_BYTES;
                  q_push      = 1'b1;
                  q_job.burst = 1'b1;
                  q_job.bytes = shifted;
                  // short frame ends on the header window itself
                  if (eff_len <= sfrx_pkg::SPAN_BYTES) begin
                     q_job.last   = 1'b1;
                     q_job.status = check_status(xor_lock, c1, c2);
                     armed_in     = 1'b0;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= '0;
         fill_ff    <= '0;
         locked_ff  <= 1'b0;
         taken_ff   <= '0;
         xor_ff     <= '0;
         chk1_ff    <= '0;
         chk2_ff    <= '0;
         elapsed_ff <= '0;
         armed_ff   <= 1'b0;
      end else begin
         window_ff  <= window_in;
         fill_ff    <= fill_in;
         locked_ff  <= locked_in;
         taken_ff   <= taken_in;
         xor_ff     <= xor_in;
         chk1_ff    <= chk1_in;
         chk2_ff    <= chk2_in;
         elapsed_ff <= elapsed_in;
         armed_ff   <= armed_in;
      end
   end

endmodule

/* hw/rtl/sfrx_queue.sv */
// two-entry job queue between front and back parts
// depends on sfrx_pkg
`timescale 1ns / 1ps

module sfrx_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sfrx_pkg::job_type   push_job,
   input  logic                pop,
   output sfrx_pkg::job_type   head_job,
   output sfrx_pkg::qstat_type stat
);

   sfrx_pkg::job_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign stat.full  = count_ff == 2'd2;
   assign stat.empty = count_ff == 2'd0;
   assign do_push = push && !stat.full;
   assign do_pop  = pop && !stat.empty;
   assign head_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* hw/rtl/sfrx_back.sv */
// back part: turns queued jobs into result words, one per cycle while rsp_ready is high
// depends on sfrx_pkg
`timescale 1ns / 1ps

module sfrx_back (
   input  logic                clock,
   input  logic                reset,
   input  sfrx_pkg::job_type   head_job,
   input  sfrx_pkg::qstat_type stat,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output sfrx_pkg::rsp_type   rsp_data
);

   logic [2:0] sub_ff, sub_in;
   logic       final_sub;
   logic       take;

   assign rsp_valid = !stat.empty;
   assign take = rsp_valid && rsp_ready;
   assign final_sub = !head_job.burst || sub_ff == sfrx_pkg::SPAN_LAST;
   assign pop = take && final_sub;

   always_comb begin
      if (head_job.burst) begin
         rsp_data.data_byte  = head_job.bytes[sub_ff];
         rsp_data.byte_index = {5'd0, sub_ff};
      end else begin
         rsp_data.data_byte  = head_job.bytes[0];
         rsp_data.byte_index = head_job.index;
      end
      // last and status ride only on the final word of a job, the last word of a burst
      rsp_data.last   = final_sub && head_job.last;
      rsp_data.status = (final_sub && head_job.last) ? head_job.status : sfrx_pkg::ST_OK;
   end

   always_comb begin
      sub_in = sub_ff;
      if (take) begin
         sub_in = final_sub ? 3'd0 : sub_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff <= '0;
      end else begin
         sub_ff <= sub_in;
      end
   end

endmodule

/* hw/rtl/servo_response_frame_receiver_core.sv */
// top level of the servo response frame receiver: csr registers, front, queue, back
// depends on sfrx_pkg, sfrx_front, sfrx_queue, sfrx_back
`timescale 1ns / 1ps

// channel  dir  handshake              payload
// req      in   req_valid / req_ready  req_data (action, rx_byte)
// rsp      out  rsp_valid / rsp_ready  rsp_data (data_byte, byte_index, last, status)
// csr      in   csr_we                 csr_index, csr_wdata
//
// one input word per cycle while the two-entry job queue has room
// a locking byte gives seven result words, walked out of the header window
// by the back part; any other result gives a single result word
// reset is synchronous; it clears state, the queue and sets csr defaults
// a stalled rsp side fills the queue and then drops req_ready

module servo_response_frame_receiver_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sfrx_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sfrx_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [15:0]       csr_wdata
);

   logic [7:0]  frame_length_ff, frame_length_in;
   logic [15:0] timeout_ff, timeout_in;
   sfrx_pkg::cfg_type   cfg;
   sfrx_pkg::job_type   push_job, head_job;
   sfrx_pkg::qstat_type qstat;
   logic q_push, q_pop;

   always_comb begin
      frame_length_in = frame_length_ff;
      timeout_in      = timeout_ff;
      if (csr_we) begin
         case (csr_index)
            sfrx_pkg::CSR_FRAME_LENGTH: frame_length_in = csr_wdata[7:0];
            sfrx_pkg::CSR_TIMEOUT:      timeout_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff <= sfrx_pkg::FRAME_LENGTH_RESET;
         timeout_ff      <= sfrx_pkg::TIMEOUT_RESET;
      end else begin
         frame_length_ff <= frame_length_in;
         timeout_ff      <= timeout_in;
      end
   end

   assign cfg.frame_length     = frame_length_ff;
   assign cfg.timeout_limit_ms = timeout_ff;

   sfrx_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (qstat.full),
      .q_push    (q_push),
      .q_job     (push_job)
   );

   sfrx_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .stat     (qstat)
   );

   sfrx_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_job  (head_job),
      .stat      (qstat),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(q_push && qstat.full))
      else $error("job pushed into full queue");

   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      !(qstat.full && qstat.empty))
      else $error("queue both full and empty");

   a_ready_tracks_queue: assert property (@(posedge clock) disable iff (reset)
      req_ready == !qstat.full)
      else $error("req_ready out of step with queue room");

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word shown right after reset");

endmodule
